[design/s2ct_pkg.sv]
// shared constants and digit helpers for the seconds to clock text block
package s2ct_pkg;

    // field widths
    localparam int RAW_W   = 32;
    localparam int FMT_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 4;
    localparam int TDATA_W = 72;

    // reciprocal constants for division by 60 and by 100, both with a 37 bit shift
    localparam logic [31:0] DIV60_MAGIC  = 32'h8888_8889;
    localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
    localparam int          DIV_SHIFT    = 37;

    // register map
    localparam logic REG_FORMAT = 1'b0;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;

    // text lengths
    localparam logic [LEN_W-1:0] LEN_SHORT = 4'd5;
    localparam logic [LEN_W-1:0] LEN_LONG  = 4'd8;

    // tens digit of a value below 100
    function automatic logic [3:0] digit_tens(input logic [6:0] v);
        logic [17:0] p;
        p = 18'(v) * 18'd205;
        return p[14:11];
    endfunction

    // units digit of a value below 100
    function automatic logic [3:0] digit_units(input logic [6:0] v);
        logic [6:0] t;
        t = 7'(digit_tens(v)) * 7'd10;
        return 4'(v - t);
    endfunction

    // ascii code of a decimal digit
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        return CH_ZERO + 8'(d);
    endfunction

endpackage

[design/seconds_to_clock_text.sv]
// seconds to clock text converter: pipelined split into h, m, s and ascii formatting
//
// Takes a 32 bit count of seconds on the s_ stream and returns the eight
// characters of a clock display on the m_ stream, with the text length and a
// seconds flag. Hours wrap modulo 100. The layout comes from the signed
// display_format register on the APB port (address 0), written while idle.
//
// Pipeline: five register stages (divide by 60 twice, modulo 100, digits and
// output register). The input transfer loads the first stage, and a result
// moves through the stages in order to the output register behind m_tvalid. One
// item is taken every cycle while s_tready is high; each division step is a
// single reciprocal multiply by a 32 bit constant, which sets the stage depth.
//
// Each stage holds its item until the next one frees up, so when the receiver
// stalls the pipeline fills and s_tready drops only once every stage is full;
// nothing is lost or repeated. Reset empties all stages and clears the format
// register to zero (H:MM layout).
module seconds_to_clock_text
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [s2ct_pkg::RAW_W-1:0]      s_tdata,   // raw_seconds[31:0]

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // char_0[7:0], char_1, ..., char_7[63:56], text_length[67:64], zero fill
    output logic [s2ct_pkg::TDATA_W-1:0]    m_tdata,
    output logic                            m_tuser,   // shows_seconds

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    // configuration
    logic [s2ct_pkg::FMT_W-1:0] fmt_reg;
    logic                       fmt_sel;

    assign fmt_sel = (paddr[2] == s2ct_pkg::REG_FORMAT);
    assign pready  = 1'b1;
    assign prdata  = fmt_sel ? {25'd0, fmt_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= '0;
        end
        else if (psel && penable && pwrite && fmt_sel)
        begin
            fmt_reg <= pwdata[s2ct_pkg::FMT_W-1:0];
        end
    end

    // stage valids and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5     = !out_valid_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                out_valid_reg <= v4_reg;
            end
        end
    end

    // stage 1: raw * (2^37 / 60)
    logic [31:0] s1_raw_reg;
    logic [63:0] s1_prod_reg;
    logic [63:0] s1_prod_next;

    assign s1_prod_next = 64'(s_tdata) * 64'(s2ct_pkg::DIV60_MAGIC);

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_raw_reg  <= s_tdata;
            s1_prod_reg <= s1_prod_next;
        end
    end

    // stage 2: total minutes, seconds, and minutes * (2^37 / 60)
    logic [26:0] q60;
    logic [31:0] q60_x60;
    logic [31:0] secs_full;
    logic [5:0]  s2_secs_reg;
    logic [26:0] s2_q60_reg;
    logic [58:0] s2_prod_reg;
    logic [58:0] s2_prod_next;

    assign q60          = s1_prod_reg[63:s2ct_pkg::DIV_SHIFT];
    assign q60_x60      = (32'(q60) << 6) - (32'(q60) << 2);
    assign secs_full    = s1_raw_reg - q60_x60;
    assign s2_prod_next = 59'(q60) * 59'(s2ct_pkg::DIV60_MAGIC);

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_secs_reg <= secs_full[5:0];
            s2_q60_reg  <= q60;
            s2_prod_reg <= s2_prod_next;
        end
    end

    // stage 3: total hours, minutes, and hours * (2^37 / 100)
    logic [20:0] hrs_full;
    logic [26:0] hrs_x60;
    logic [26:0] mins_full;
    logic [5:0]  s3_secs_reg;
    logic [5:0]  s3_mins_reg;
    logic [20:0] s3_hrs_reg;
    logic [51:0] s3_prod_reg;
    logic [51:0] s3_prod_next;

    assign hrs_full     = s2_prod_reg[57:s2ct_pkg::DIV_SHIFT];
    assign hrs_x60      = (27'(hrs_full) << 6) - (27'(hrs_full) << 2);
    assign mins_full    = s2_q60_reg - hrs_x60;
    assign s3_prod_next = 52'(hrs_full) * 52'(s2ct_pkg::DIV100_MAGIC);

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_secs_reg <= s2_secs_reg;
            s3_mins_reg <= mins_full[5:0];
            s3_hrs_reg  <= hrs_full;
            s3_prod_reg <= s3_prod_next;
        end
    end

    // stage 4: hours modulo 100
    logic [13:0] hq;
    logic [20:0] hq_x100;
    logic [20:0] hrs_mod;
    logic [5:0]  s4_secs_reg;
    logic [5:0]  s4_mins_reg;
    logic [6:0]  s4_hrs_reg;

    assign hq      = s3_prod_reg[50:s2ct_pkg::DIV_SHIFT];
    assign hq_x100 = 21'(hq) * 21'd100;
    assign hrs_mod = s3_hrs_reg - hq_x100;

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            s4_secs_reg <= s3_secs_reg;
            s4_mins_reg <= s3_mins_reg;
            s4_hrs_reg  <= hrs_mod[6:0];
        end
    end

    // stage 5: layout selection and ascii
    logic                              lead;
    logic [6:0]                        mag;
    logic                              long_form;
    logic                              use_secs;
    logic                              min_sec_form;
    logic [6:0]                        first_grp;
    logic [6:0]                        second_grp;
    logic [3:0]                        first_tens;
    logic [s2ct_pkg::TDATA_W-1:0]      m_data_next;
    logic [s2ct_pkg::TDATA_W-1:0]      m_data_reg;
    logic                              m_user_reg;
    logic [s2ct_pkg::CHAR_W-1:0]       c0, c5, c6, c7;
    logic [s2ct_pkg::LEN_W-1:0]        text_len;

    assign lead = fmt_reg[6];
    assign mag  = lead ? 7'(8'd128 - {1'b0, fmt_reg}) : fmt_reg;

    always_comb
    begin
        long_form = (mag == 7'd1);
        if (mag == 7'd0)
        begin
            use_secs = 1'b0;
        end
        else if (mag == 7'd1)
        begin
            use_secs = 1'b1;
        end
        else
        begin
            // minutes and seconds while under the threshold with no hours
            use_secs = (s4_hrs_reg == 7'd0) && (7'(s4_mins_reg) < mag);
        end
    end

    assign min_sec_form = use_secs && !long_form;
    assign first_grp    = min_sec_form ? 7'(s4_mins_reg) : s4_hrs_reg;
    assign second_grp   = min_sec_form ? 7'(s4_secs_reg) : 7'(s4_mins_reg);
    assign first_tens   = s2ct_pkg::digit_tens(first_grp);

    assign c0 = (first_tens != 4'd0 || lead) ? s2ct_pkg::digit_char(first_tens)
                                             : s2ct_pkg::CH_SPACE;
    assign c5 = long_form ? s2ct_pkg::CH_COLON : s2ct_pkg::CH_SPACE;
    assign c6 = long_form ? s2ct_pkg::digit_char(s2ct_pkg::digit_tens(7'(s4_secs_reg)))
                          : s2ct_pkg::CH_SPACE;
    assign c7 = long_form ? s2ct_pkg::digit_char(s2ct_pkg::digit_units(7'(s4_secs_reg)))
                          : s2ct_pkg::CH_SPACE;
    assign text_len = long_form ? s2ct_pkg::LEN_LONG : s2ct_pkg::LEN_SHORT;

    assign m_data_next = {4'd0, text_len, c7, c6, c5,
                          s2ct_pkg::digit_char(s2ct_pkg::digit_units(second_grp)),
                          s2ct_pkg::digit_char(s2ct_pkg::digit_tens(second_grp)),
                          s2ct_pkg::CH_COLON,
                          s2ct_pkg::digit_char(s2ct_pkg::digit_units(first_grp)),
                          c0};

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            m_data_reg <= m_data_next;
            m_user_reg <= use_secs;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
